### hw/rtl/lfsa_pkg.sv
// ----------------------------------------------------------------------------
// lfsa_pkg: shared types and constants of the lowest-free slot allocator
// Beat structs, register indexes, reset values and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package lfsa_pkg;

    localparam int SLOT_W    = 20;
    localparam int CNT_W     = 7;
    localparam int STRIDE_W  = 13;
    localparam int ADDR_W    = 64;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = SLOT_W + STRIDE_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_SLOT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_BYTES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_BASE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GPU_BASE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GPU_VISIBLE  = 3'd5;

    // Request actions
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Largest batch one request may ask for
    localparam logic [CNT_W-1:0] RESULT_LIMIT = 7'd64;

    // Register reset values
    localparam logic [SLOT_W-1:0]   RST_START_SLOT  = 20'd0;
    localparam logic [CNT_W-1:0]    RST_SLOT_COUNT  = 7'd64;
    localparam logic [STRIDE_W-1:0] RST_STRIDE      = 13'd32;
    localparam logic [ADDR_W-1:0]   RST_BASE        = 64'd0;
    localparam logic                RST_GPU_VISIBLE = 1'b0;

    typedef struct packed {
        logic              action;
        logic [CNT_W-1:0]  want_count;
        logic [SLOT_W-1:0] release_slot;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0] granted_slot;
        logic [ADDR_W-1:0] cpu_address;
        logic [ADDR_W-1:0] gpu_address;
        logic              gpu_valid;
        logic              shortage;
        logic              last;
    } t_res;

    // One beat handed from the sequencer to the address unit
    typedef struct packed {
        logic              valid;
        logic              shortage;
        logic              last;
        logic [SLOT_W-1:0] slot;
    } t_issue;

    // Free map commands from the sequencer
    typedef struct packed {
        logic clear;
        logic free_en;
        logic take;
    } t_map_ctl;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_GRANT = 2'b10
    } t_state;

endpackage

`default_nettype wire

### hw/rtl/lfsa_map.sv
// ----------------------------------------------------------------------------
// lfsa_map: free map and free count
// Keeps one free bit per slot, finds the lowest free slot, takes and returns slots.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsa_map #(
    parameter int  MAX_SLOTS = 64,
    localparam int TW        = $clog2(MAX_SLOTS + 1),
    localparam int IW        = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  lfsa_pkg::t_map_ctl              i_ctl,
    input  wire [lfsa_pkg::SLOT_W-1:0]      i_release_slot,
    input  wire [lfsa_pkg::SLOT_W-1:0]      i_start_slot,
    input  wire [lfsa_pkg::CNT_W-1:0]       i_slot_count,
    input  wire [lfsa_pkg::CNT_W-1:0]       i_clear_count,
    output logic [TW-1:0]                   o_free_total,
    output logic [lfsa_pkg::SLOT_W-1:0]     o_grant_slot
);

    logic [MAX_SLOTS-1:0]        r_map;
    logic [TW-1:0]               r_total;
    logic [MAX_SLOTS-1:0]        low_oh;
    logic [IW-1:0]               low_idx;
    logic [lfsa_pkg::SLOT_W-1:0] rel_off;
    logic [TW-1:0]               live;
    logic                        in_range;

    function automatic logic [TW-1:0] live_of(input logic [lfsa_pkg::CNT_W-1:0] cnt);
        logic [TW-1:0] v;
        if (int'(cnt) > MAX_SLOTS) begin
            v = TW'(MAX_SLOTS);
        end else begin
            v = TW'(cnt);
        end
        return v;
    endfunction

    function automatic logic [MAX_SLOTS-1:0] fill_of(input logic [TW-1:0] cnt);
        logic [MAX_SLOTS-1:0] m;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            m[i] = (i < int'(cnt));
        end
        return m;
    endfunction

    // Isolate the lowest set bit and encode it
    always_comb begin
        low_oh  = r_map & (~r_map + MAX_SLOTS'(1));
        low_idx = '0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            if (low_oh[i]) begin
                low_idx = low_idx | IW'(i);
            end
        end
    end

    always_comb begin
        live     = live_of(i_slot_count);
        rel_off  = i_release_slot - i_start_slot;
        in_range = (rel_off < lfsa_pkg::SLOT_W'(live));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map   <= fill_of(live_of(lfsa_pkg::RST_SLOT_COUNT));
            r_total <= live_of(lfsa_pkg::RST_SLOT_COUNT);
        end else if (i_ctl.clear) begin
            r_map   <= fill_of(live_of(i_clear_count));
            r_total <= live_of(i_clear_count);
        end else if (i_ctl.free_en) begin
            if (in_range && !r_map[rel_off[IW-1:0]]) begin
                r_map[rel_off[IW-1:0]] <= 1'b1;
                r_total                <= r_total + TW'(1);
            end
        end else if (i_ctl.take) begin
            r_map   <= r_map & ~low_oh;
            r_total <= r_total - TW'(1);
        end
    end

    assign o_free_total = r_total;
    assign o_grant_slot = i_start_slot + lfsa_pkg::SLOT_W'(low_idx);

endmodule

`default_nettype wire

### hw/rtl/lfsa_addr.sv
// ----------------------------------------------------------------------------
// lfsa_addr: address unit
// Multiplies slot by stride, then adds the CPU and GPU bases; two stages.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsa_addr (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  lfsa_pkg::t_issue               i_issue,
    input  wire [lfsa_pkg::STRIDE_W-1:0]   i_stride,
    input  wire [lfsa_pkg::ADDR_W-1:0]     i_cpu_base,
    input  wire [lfsa_pkg::ADDR_W-1:0]     i_gpu_base,
    input  wire                            i_gpu_visible,
    output logic                           o_valid,
    output lfsa_pkg::t_res                 o_res
);

    lfsa_pkg::t_issue              r_s1;
    logic [lfsa_pkg::PROD_W-1:0]   r_prod;
    logic                          r_valid;
    lfsa_pkg::t_res                r_res;
    logic [lfsa_pkg::ADDR_W-1:0]   delta;

    assign delta = lfsa_pkg::ADDR_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_s1.valid <= i_issue.valid;
            r_valid    <= r_s1.valid;
        end
        r_s1.shortage <= i_issue.shortage;
        r_s1.last     <= i_issue.last;
        r_s1.slot     <= i_issue.slot;
        r_prod        <= lfsa_pkg::PROD_W'(i_issue.slot) * lfsa_pkg::PROD_W'(i_stride);
        if (r_s1.shortage) begin
            r_res.granted_slot <= '0;
            r_res.cpu_address  <= '0;
            r_res.gpu_address  <= '0;
            r_res.gpu_valid    <= 1'b0;
            r_res.shortage     <= 1'b1;
            r_res.last         <= 1'b1;
        end else begin
            r_res.granted_slot <= r_s1.slot;
            r_res.cpu_address  <= i_cpu_base + delta;
            r_res.gpu_address  <= i_gpu_visible ? (i_gpu_base + delta) : '0;
            r_res.gpu_valid    <= i_gpu_visible;
            r_res.shortage     <= 1'b0;
            r_res.last         <= r_s1.last;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

### hw/rtl/lowest_free_slot_allocator_top.sv
// A free updates the free map and gives no beat. An allocate of N slots holds busy
// while it grants them; its beats leave the address unit registers one per cycle.
// A shortage beat is issued in the start cycle and busy stays low.
// Throughput: one granted slot per cycle, set by the single find-lowest/clear of the map.
// Reset (synchronous, active low) restores the register defaults and frees the range.
// ----------------------------------------------------------------------------
// lowest_free_slot_allocator_top: lowest-free-first descriptor slot allocator
// Sequencer that grants slots one per cycle from the free map and feeds the
// shared address unit; configuration registers and the free map clear.
// ----------------------------------------------------------------------------
`default_nettype none

module lowest_free_slot_allocator_top #(
    parameter int  MAX_SLOTS = 64,
    localparam int TW        = $clog2(MAX_SLOTS + 1)
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // command side
    input  wire                              i_start,
    output logic                             o_busy,
    input  lfsa_pkg::t_req                   i_req,
    // result side, one strobe per beat, no back-pressure
    output logic                             o_res_valid,
    output lfsa_pkg::t_res                   o_res,
    // configuration write port
    input  wire                              i_cfg_we,
    input  wire [lfsa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [lfsa_pkg::ADDR_W-1:0]       i_cfg_wdata
);

    // Configuration registers
    logic [lfsa_pkg::SLOT_W-1:0]   r_start_slot;
    logic [lfsa_pkg::CNT_W-1:0]    r_slot_count;
    logic [lfsa_pkg::CNT_W-1:0]    n_slot_count;
    logic [lfsa_pkg::STRIDE_W-1:0] r_stride;
    logic [lfsa_pkg::ADDR_W-1:0]   r_cpu_base;
    logic [lfsa_pkg::ADDR_W-1:0]   r_gpu_base;
    logic                          r_gpu_visible;
    logic                          cfg_hit;

    // Sequencer
    lfsa_pkg::t_state              r_state;
    logic [lfsa_pkg::CNT_W-1:0]    r_remain;
    logic                          accept;
    logic                          too_many;

    lfsa_pkg::t_map_ctl            map_ctl;
    lfsa_pkg::t_issue              issue;
    logic [TW-1:0]                 free_total;
    logic [lfsa_pkg::SLOT_W-1:0]   grant_slot;

    // Decode the register index; an index past the list writes nothing and clears nothing
    always_comb begin
        cfg_hit      = 1'b0;
        n_slot_count = r_slot_count;
        unique case (i_cfg_idx)
            lfsa_pkg::CFG_START_SLOT,
            lfsa_pkg::CFG_STRIDE_BYTES,
            lfsa_pkg::CFG_CPU_BASE,
            lfsa_pkg::CFG_GPU_BASE,
            lfsa_pkg::CFG_GPU_VISIBLE: begin
                cfg_hit = i_cfg_we;
            end
            lfsa_pkg::CFG_SLOT_COUNT: begin
                cfg_hit = i_cfg_we;
                if (i_cfg_we) begin
                    n_slot_count = i_cfg_wdata[lfsa_pkg::CNT_W-1:0];
                end
            end
            default: begin
                cfg_hit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_slot  <= lfsa_pkg::RST_START_SLOT;
            r_slot_count  <= lfsa_pkg::RST_SLOT_COUNT;
            r_stride      <= lfsa_pkg::RST_STRIDE;
            r_cpu_base    <= lfsa_pkg::RST_BASE;
            r_gpu_base    <= lfsa_pkg::RST_BASE;
            r_gpu_visible <= lfsa_pkg::RST_GPU_VISIBLE;
        end else begin
            r_slot_count <= n_slot_count;
            if (i_cfg_we && (i_cfg_idx == lfsa_pkg::CFG_START_SLOT)) begin
                r_start_slot <= i_cfg_wdata[lfsa_pkg::SLOT_W-1:0];
            end
            if (i_cfg_we && (i_cfg_idx == lfsa_pkg::CFG_STRIDE_BYTES)) begin
                r_stride <= i_cfg_wdata[lfsa_pkg::STRIDE_W-1:0];
            end
            if (i_cfg_we && (i_cfg_idx == lfsa_pkg::CFG_CPU_BASE)) begin
                r_cpu_base <= i_cfg_wdata;
            end
            if (i_cfg_we && (i_cfg_idx == lfsa_pkg::CFG_GPU_BASE)) begin
                r_gpu_base <= i_cfg_wdata;
            end
            if (i_cfg_we && (i_cfg_idx == lfsa_pkg::CFG_GPU_VISIBLE)) begin
                r_gpu_visible <= i_cfg_wdata[0];
            end
        end
    end

    // Take a command only in idle; a shortage is decided right at the start cycle
    assign o_busy   = (r_state != lfsa_pkg::ST_IDLE);
    assign accept   = i_start && (r_state == lfsa_pkg::ST_IDLE);
    assign too_many = (int'(i_req.want_count) > int'(free_total))
                   || (i_req.want_count > lfsa_pkg::RESULT_LIMIT);

    always_comb begin
        map_ctl.clear   = cfg_hit;
        map_ctl.free_en = accept && (i_req.action == lfsa_pkg::ACT_FREE);
        map_ctl.take    = (r_state == lfsa_pkg::ST_GRANT);

        issue          = '0;
        if (r_state == lfsa_pkg::ST_GRANT) begin
            // Grant the lowest free slot this cycle; mark the final one
            issue.valid = 1'b1;
            issue.slot  = grant_slot;
            issue.last  = (r_remain == lfsa_pkg::CNT_W'(1));
        end else if (accept && (i_req.action == lfsa_pkg::ACT_ALLOC)
                     && (i_req.want_count != '0) && too_many) begin
            // Send one shortage beat and allocate nothing
            issue.valid    = 1'b1;
            issue.shortage = 1'b1;
            issue.last     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lfsa_pkg::ST_IDLE;
            r_remain <= '0;
        end else begin
            unique case (r_state)
                lfsa_pkg::ST_IDLE: begin
                    if (accept && (i_req.action == lfsa_pkg::ACT_ALLOC)
                        && (i_req.want_count != '0) && !too_many) begin
                        r_remain <= i_req.want_count;
                        r_state  <= lfsa_pkg::ST_GRANT;
                    end
                end
                lfsa_pkg::ST_GRANT: begin
                    r_remain <= r_remain - lfsa_pkg::CNT_W'(1);
                    if (r_remain == lfsa_pkg::CNT_W'(1)) begin
                        r_state <= lfsa_pkg::ST_IDLE;
                    end
                end
                default: begin
                    r_state <= lfsa_pkg::ST_IDLE;
                end
            endcase
        end
    end

    lfsa_map #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_map (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (map_ctl),
        .i_release_slot (i_req.release_slot),
        .i_start_slot   (r_start_slot),
        .i_slot_count   (r_slot_count),
        .i_clear_count  (n_slot_count),
        .o_free_total   (free_total),
        .o_grant_slot   (grant_slot)
    );

    // Addresses use the register values as they stand; the user must hold the values of the
    // idle window until every beat of the request has left, which the block does not enforce
    lfsa_addr u_addr (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_issue       (issue),
        .i_stride      (r_stride),
        .i_cpu_base    (r_cpu_base),
        .i_gpu_base    (r_gpu_base),
        .i_gpu_visible (r_gpu_visible),
        .o_valid       (o_res_valid),
        .o_res         (o_res)
    );

endmodule

`default_nettype wire

### hw/rtl/lfsa_checker.sv
// ----------------------------------------------------------------------------
// lfsa_checker: port-level checks of the slot allocator
// Watches commands and result beats over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsa_checker (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    input  wire                              o_busy,
    input  lfsa_pkg::t_req                   i_req,
    input  wire                              o_res_valid,
    input  lfsa_pkg::t_res                   o_res
);

    // A shortage beat is always the only and final beat, with empty fields
    a_shortage_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.shortage)
        |-> (o_res.last && (o_res.granted_slot == '0) && !o_res.gpu_valid))
        else $error("shortage beat carries data or is not last");

    // No GPU address leaks out when the heap is not GPU visible
    a_gpu_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.gpu_valid) |-> (o_res.gpu_address == '0))
        else $error("gpu address without gpu_valid");

    // A free command never produces a result beat
    a_free_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_req.action == lfsa_pkg::ACT_FREE))
        |-> ##2 !o_res_valid)
        else $error("free produced a result beat");

    // An oversized batch gives a shortage beat
    a_oversize: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_req.action == lfsa_pkg::ACT_ALLOC)
         && (i_req.want_count > lfsa_pkg::RESULT_LIMIT))
        |-> ##2 (o_res_valid && o_res.shortage))
        else $error("oversized request did not report shortage");

endmodule

bind lowest_free_slot_allocator_top lfsa_checker u_lfsa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .i_req       (i_req),
    .o_res_valid (o_res_valid),
    .o_res       (o_res)
);

`default_nettype wire
